@@ sv/ipv4lpm_pkg.sv @@
// Package: shared types, codes and helpers for the IPv4 longest-prefix router.
`timescale 1ns / 1ps

package ipv4lpm_pkg;

  localparam int unsigned MaxRoutesDefault      = 64;
  localparam int unsigned InterfaceCountDefault = 16;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned LenW   = 6;
  localparam int unsigned IfcW   = 4;
  localparam int unsigned TtlW   = 8;
  localparam int unsigned StatW  = 3;
  localparam int unsigned MaxLen = 32;

  localparam int unsigned InDataW  = 120;  // 115 bits of fields, padded to bytes
  localparam int unsigned OutDataW = 48;   // 44 bits of fields, padded to bytes

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_ROUTE = 1'b1;

  typedef enum logic [StatW-1:0] {
    ST_ADDED       = 3'd0,
    ST_FORWARDED   = 3'd1,
    ST_NO_ROUTE    = 3'd2,
    ST_TTL_EXPIRED = 3'd3,
    ST_TABLE_FULL  = 3'd4
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_SEARCH
  } fsm_e;

  // One stored route.
  typedef struct packed {
    logic [AddrW-1:0] prefix;
    logic [LenW-1:0]  len;
    logic             gw_valid;
    logic [AddrW-1:0] gw;
    logic [IfcW-1:0]  port;
  } route_t;

  // Lookup state handed from cell to cell.
  typedef struct packed {
    logic [AddrW-1:0] dst;
    logic             found;
    logic [LenW-1:0]  best_len;
    logic             gw_valid;
    logic [AddrW-1:0] gw;
    logic [IfcW-1:0]  port;
  } carry_t;

  // High-order ones for a prefix length of 0..32.
  function automatic logic [AddrW-1:0] len_mask(input logic [LenW-1:0] len);
    len_mask = ~({AddrW{1'b1}} >> len);
  endfunction

endpackage

@@ sv/ipv4lpm_cell.sv @@
// Route cell: holds one route and updates the passing lookup with its match.
`timescale 1ns / 1ps

module ipv4lpm_cell
  import ipv4lpm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_en_i,
  input  route_t wr_route_i,
  input  logic   active_i,   // cell holds a written route
  input  logic   vld_i,
  input  carry_t carry_i,
  output logic   vld_o,
  output carry_t carry_o
);

  route_t route_q;
  logic   vld_q;
  carry_t carry_q, carry_d;
  logic   hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      route_q <= wr_route_i;
    end
  end

  assign hit = active_i &&
               (((route_q.prefix ^ carry_i.dst) & len_mask(route_q.len)) == '0) &&
               (!carry_i.found || (route_q.len > carry_i.best_len));

  always_comb begin
    carry_d = carry_i;
    if (hit) begin
      carry_d.found    = 1'b1;
      carry_d.best_len = route_q.len;
      carry_d.gw_valid = route_q.gw_valid;
      carry_d.gw       = route_q.gw;
      carry_d.port     = route_q.port;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      carry_q <= carry_d;
    end
  end

  assign vld_o   = vld_q;
  assign carry_o = carry_q;

endmodule

@@ sv/ipv4_longest_prefix_router_top.sv @@
// Top level: IPv4 route table as a chain of route cells with longest-prefix lookup.
`timescale 1ns / 1ps
//
//  Channel  Dir  Group        Payload
//  -------  ---  -----------  -----------------------------------------------------
//  in       in   s_axis_*     tuser: action; tdata: add-route and lookup fields
//  out      out  m_axis_*     tuser: status; tdata: interface, hop address, TTL
//
//  An add transfer's result is loaded into the output register in the cycle after
//  acceptance. A lookup walks the cell chain one cell per cycle, then loads its
//  result into the output register; the next item is taken once the FSM is idle.
//  One item is in work at a time. The result sits in an output register; a new
//  item is accepted while that register drains in the same cycle.
//  Reset clears the route count, the FSM and all valid flags; route cells are
//  not cleared, cells at or above the route count are ignored by lookups.
//  A stalled output only holds back the input; no result is ever dropped.

module ipv4_longest_prefix_router_top
  import ipv4lpm_pkg::*;
#(
  parameter int unsigned MAX_ROUTES      = MaxRoutesDefault,
  parameter int unsigned INTERFACE_COUNT = InterfaceCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [31:0] net_prefix, [37:32] mask_len, [38] has_next_hop,
  // [70:39] next_hop_ip, [74:71] interface_index, [106:75] dest_ip,
  // [114:107] ttl_in, [119:115] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [0] action
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [3:0] out_interface, [35:4] hop_address, [43:36] ttl_out, [47:44] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // [2:0] status
  output logic [StatW-1:0]    m_axis_tuser_o
);

  localparam int unsigned CntW = $clog2(MAX_ROUTES + 1);

  // Input fields
  logic [AddrW-1:0] in_prefix, in_gw, in_dst;
  logic [LenW-1:0]  in_len, len_sat;
  logic             in_has_gw;
  logic [IfcW-1:0]  in_ifc, ifc_sat;
  logic [TtlW-1:0]  in_ttl;

  assign in_prefix = s_axis_tdata_i[31:0];
  assign in_len    = s_axis_tdata_i[37:32];
  assign in_has_gw = s_axis_tdata_i[38];
  assign in_gw     = s_axis_tdata_i[70:39];
  assign in_ifc    = s_axis_tdata_i[74:71];
  assign in_dst    = s_axis_tdata_i[106:75];
  assign in_ttl    = s_axis_tdata_i[114:107];

  // Saturate length to 32 and the interface to the last one present
  assign len_sat = (in_len > LenW'(MaxLen)) ? LenW'(MaxLen) : in_len;
  assign ifc_sat = ({1'b0, 8'(in_ifc)} >= 9'(INTERFACE_COUNT))
                   ? IfcW'(INTERFACE_COUNT - 1) : in_ifc;

  logic s_fire, m_fire, is_route, full, add_ok;
  fsm_e state_q, state_d;
  logic [CntW-1:0] count_q;
  logic [TtlW-1:0] ttl_q;

  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_route = (s_axis_tuser_i == ACT_ROUTE);
  assign full     = (count_q == CntW'(MAX_ROUTES));
  assign add_ok   = s_fire && (s_axis_tuser_i == ACT_ADD) && !full;

  // Cell chain
  route_t                wr_route;
  carry_t                carry [MAX_ROUTES+1];
  logic [MAX_ROUTES:0]   carry_vld;

  assign wr_route = '{prefix: in_prefix, len: len_sat, gw_valid: in_has_gw,
                      gw: in_gw, port: ifc_sat};

  assign carry_vld[0] = s_fire && is_route;
  assign carry[0]     = '{dst: in_dst, found: 1'b0, best_len: '0, gw_valid: 1'b0,
                          gw: '0, port: '0};

  for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
    ipv4lpm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (add_ok && (count_q == CntW'(i))),
      .wr_route_i (wr_route),
      .active_i   (CntW'(i) < count_q),
      .vld_i      (carry_vld[i]),
      .carry_i    (carry[i]),
      .vld_o      (carry_vld[i+1]),
      .carry_o    (carry[i+1])
    );
  end

  logic   tail_vld;
  carry_t tail;
  assign tail_vld = carry_vld[MAX_ROUTES];
  assign tail     = carry[MAX_ROUTES];

  // Output register
  logic             res_vld_q, res_vld_d, load;
  status_e          res_status_q, ld_status;
  logic [IfcW-1:0]  res_ifc_q, ld_ifc;
  logic [AddrW-1:0] res_hop_q, ld_hop;
  logic [TtlW-1:0]  res_ttl_q, ld_ttl;

  assign m_fire = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    state_d   = state_q;
    load      = 1'b0;
    ld_status = ST_ADDED;
    ld_ifc    = '0;
    ld_hop    = '0;
    ld_ttl    = '0;
    case (state_q)
      FSM_IDLE: begin
        if (s_fire) begin
          if (is_route) begin
            state_d = FSM_SEARCH;
          end else begin
            load      = 1'b1;
            ld_status = full ? ST_TABLE_FULL : ST_ADDED;
          end
        end
      end
      FSM_SEARCH: begin
        if (tail_vld) begin
          state_d = FSM_IDLE;
          load    = 1'b1;
          if (!tail.found) begin
            ld_status = ST_NO_ROUTE;
          end else if (ttl_q <= TtlW'(1)) begin
            ld_status = ST_TTL_EXPIRED;
          end else begin
            ld_status = ST_FORWARDED;
            ld_ifc    = tail.port;
            ld_hop    = tail.gw_valid ? tail.gw : tail.dst;
            ld_ttl    = ttl_q - TtlW'(1);
          end
        end
      end
      default: state_d = FSM_IDLE;
    endcase
    res_vld_d = load ? 1'b1 : (m_fire ? 1'b0 : res_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      count_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
      if (add_ok) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && is_route) begin
      ttl_q <= in_ttl;
    end
    if (load) begin
      res_status_q <= ld_status;
      res_ifc_q    <= ld_ifc;
      res_hop_q    <= ld_hop;
      res_ttl_q    <= ld_ttl;
    end
  end

  // The output register is empty or draining whenever an item is taken,
  // so a finished lookup always finds it free.
  assign s_axis_tready_o = (state_q == FSM_IDLE) && (!res_vld_q || m_axis_tready_i);
  assign m_axis_tvalid_o = res_vld_q;
  assign m_axis_tuser_o  = res_status_q;
  assign m_axis_tdata_o  = {4'b0, res_ttl_q, res_hop_q, res_ifc_q};

  // Checks
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(carry_vld[MAX_ROUTES:1]))
    else $error("more than one lookup in the cell chain");

  a_tail_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_vld |-> (state_q == FSM_SEARCH))
    else $error("lookup left the chain outside a search");

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_vld |-> !res_vld_q)
    else $error("lookup result would overwrite a pending result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ROUTES))
    else $error("route count beyond table size");

endmodule

@@ tb/ipv4_longest_prefix_router_top_tb.sv @@
// Testbench: directed and randomized route-table and lookup checks of the IPv4 router.
`timescale 1ns / 1ps

module ipv4_longest_prefix_router_top_tb;
  import ipv4lpm_pkg::*;

  localparam int unsigned MAX_ROUTES      = MaxRoutesDefault;
  localparam int unsigned INTERFACE_COUNT = InterfaceCountDefault;
  localparam int unsigned HOLD_CYCLES     = 400;   // long output hold-off
  localparam int unsigned STALL_LIMIT     = 4000;  // cycles without any transfer
  localparam int unsigned SETTLE_CYCLES   = 2 * MAX_ROUTES + 16;
  localparam int unsigned MAX_PRINTS      = 40;
  localparam int unsigned ADD_PCT         = 15;

  // Input transfer layout, lowest field last.
  typedef struct packed {
    logic [4:0]       pad;
    logic [TtlW-1:0]  ttl;
    logic [AddrW-1:0] dst;
    logic [IfcW-1:0]  ifc;
    logic [AddrW-1:0] gw;
    logic             gw_valid;
    logic [LenW-1:0]  len;
    logic [AddrW-1:0] prefix;
  } route_item_t;

  // Output transfer layout, lowest field last.
  typedef struct packed {
    logic [3:0]       pad;
    logic [TtlW-1:0]  ttl;
    logic [AddrW-1:0] hop;
    logic [IfcW-1:0]  port;
  } hop_word_t;

  typedef struct {
    status_e          status;
    logic [IfcW-1:0]  port;
    logic [AddrW-1:0] hop;
    logic [TtlW-1:0]  ttl;
  } verdict_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [StatW-1:0]    m_axis_tuser_o;

  // Shadow route table, updated as add transfers are accepted.
  logic [AddrW-1:0] tbl_prefix   [MAX_ROUTES];
  logic [LenW-1:0]  tbl_len      [MAX_ROUTES];
  logic             tbl_gw_valid [MAX_ROUTES];
  logic [AddrW-1:0] tbl_gw       [MAX_ROUTES];
  logic [IfcW-1:0]  tbl_port     [MAX_ROUTES];
  int unsigned      tbl_count;

  verdict_t    pending_verdicts[$];
  verdict_t    want;
  hop_word_t   got;
  int unsigned mismatch_cnt;
  int unsigned status_seen[5];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned idle_run;

  ipv4_longest_prefix_router_top #(
    .MAX_ROUTES      (MAX_ROUTES),
    .INTERFACE_COUNT (INTERFACE_COUNT)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [AddrW-1:0] prefix_mask(input int unsigned len);
    if (len == 0) return '0;
    if (len > MaxLen) len = MaxLen;
    return {AddrW{1'b1}} << (AddrW - len);
  endfunction

  // Applies one accepted transfer to the shadow table and returns its outcome.
  function automatic verdict_t forward_decision(input logic act, input route_item_t it);
    verdict_t         v;
    logic [AddrW-1:0] dst;
    int unsigned      len;
    int unsigned      port;
    int unsigned      best;
    bit               found;
    v.status = ST_ADDED;
    v.port   = '0;
    v.hop    = '0;
    v.ttl    = '0;
    if (act == ACT_ADD) begin
      if (tbl_count >= MAX_ROUTES) begin
        v.status = ST_TABLE_FULL;
      end else begin
        len  = 32'(it.len);
        port = 32'(it.ifc);
        if (len > MaxLen) len = MaxLen;
        if (port >= INTERFACE_COUNT) port = INTERFACE_COUNT - 1;
        tbl_prefix[tbl_count]   = it.prefix;
        tbl_len[tbl_count]      = LenW'(len);
        tbl_gw_valid[tbl_count] = it.gw_valid;
        tbl_gw[tbl_count]       = it.gw;
        tbl_port[tbl_count]     = IfcW'(port);
        tbl_count++;
      end
    end else begin
      dst   = it.dst;
      found = 1'b0;
      best  = 0;
      for (int unsigned i = 0; i < tbl_count; i++) begin
        // strictly longer wins, so the earliest route keeps a tie
        if ((((tbl_prefix[i] ^ dst) & prefix_mask(32'(tbl_len[i]))) == '0) &&
            (!found || tbl_len[i] > tbl_len[best])) begin
          best  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        v.status = ST_NO_ROUTE;
      end else if (it.ttl <= TtlW'(1)) begin
        v.status = ST_TTL_EXPIRED;
      end else begin
        v.status = ST_FORWARDED;
        v.port   = tbl_port[best];
        v.hop    = tbl_gw_valid[best] ? tbl_gw[best] : dst;
        v.ttl    = it.ttl - TtlW'(1);
      end
    end
    status_seen[v.status]++;
    return v;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_cnt < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Offers one item, holds it until the transfer, then records its outcome.
  task automatic send_item(input logic act, input route_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= it;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_verdicts.push_back(forward_decision(act, it));
  endtask

  task automatic send_add(input logic [AddrW-1:0] prefix, input int unsigned len,
                          input logic gw_valid, input logic [AddrW-1:0] gw,
                          input int unsigned ifc);
    route_item_t it;
    it          = '0;
    it.prefix   = prefix;
    it.len      = LenW'(len);
    it.gw_valid = gw_valid;
    it.gw       = gw;
    it.ifc      = IfcW'(ifc);
    send_item(ACT_ADD, it);
  endtask

  task automatic send_lookup(input logic [AddrW-1:0] dst, input int unsigned ttl);
    route_item_t it;
    it     = '0;
    it.dst = dst;
    it.ttl = TtlW'(ttl);
    send_item(ACT_ROUTE, it);
  endtask

  // Random item; about half of the adds nest inside a stored route and most lookups
  // aim at a stored prefix so that longest-match selection gets exercised.
  task automatic send_random(input int unsigned add_pct);
    route_item_t      it;
    logic             act;
    int unsigned      k;
    int unsigned      r;
    logic [AddrW-1:0] m;
    it.pad      = '0;
    it.prefix   = $urandom();
    it.gw       = $urandom();
    it.dst      = $urandom();
    it.gw_valid = 1'($urandom_range(1));
    it.ifc      = IfcW'($urandom_range(15));
    it.ttl      = TtlW'($urandom_range(255));
    it.len      = LenW'($urandom_range(63));
    act = ($urandom_range(99) < add_pct) ? ACT_ADD : ACT_ROUTE;
    if (act == ACT_ADD) begin
      r = $urandom_range(99);
      if (tbl_count > 0 && r < 50) begin
        k         = $urandom_range(tbl_count - 1);
        m         = prefix_mask(32'(tbl_len[k]));
        it.len    = LenW'($urandom_range(MaxLen, 32'(tbl_len[k])));
        it.prefix = (tbl_prefix[k] & m) | (it.prefix & ~m);
      end else if (r < 52) begin
        it.len = '0;
      end else if (r < 60) begin
        it.len = LenW'($urandom_range(63, MaxLen + 1));
      end else begin
        it.len = LenW'($urandom_range(MaxLen, 1));
      end
    end else begin
      if ($urandom_range(99) < 25) it.ttl = TtlW'($urandom_range(2));
      if (tbl_count > 0 && $urandom_range(99) < 75) begin
        k      = $urandom_range(tbl_count - 1);
        m      = prefix_mask(32'(tbl_len[k]));
        it.dst = (tbl_prefix[k] & m) | (it.dst & ~m);
      end
    end
    send_item(act, it);
  endtask

  // Stops offering and waits for every outstanding result.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_table();
    send_lookup(32'h0000_0000, 0);
    send_lookup(32'hFFFF_FFFF, 1);
    send_lookup(32'h1234_5678, 255);
    wait_drained();
  endtask

  task automatic test_directed_routes();
    send_add(32'hC0A8_0000, 16, 1'b1, 32'hC0A8_0001, 1);
    send_add(32'hC0A8_0100, 24, 1'b0, 32'hDEAD_BEEF, 2);  // gateway ignored
    send_add(32'hC0A8_0000, 16, 1'b1, 32'h0A0A_0A0A, 3);  // tie, loses to first
    send_add(32'hFFFF_FFFF, 63, 1'b1, 32'hFFFF_FFFF, 15); // length saturates
    send_add(32'h0000_0000, 32, 1'b0, 32'h0000_0000, 0);
    send_add(32'h8000_0000, 1,  1'b1, 32'h0102_0304, 7);
    send_lookup(32'hC0A8_0105, 64);
    send_lookup(32'hC0A8_FF01, 2);
    send_lookup(32'hC0A8_0105, 1);
    send_lookup(32'hC0A8_0105, 0);
    send_lookup(32'hFFFF_FFFF, 255);
    send_lookup(32'hFFFF_FFFE, 255);
    send_lookup(32'h0000_0000, 128);
    send_lookup(32'h0000_0001, 0);                        // no match wins over low TTL
    send_lookup(32'h7FFF_FFFF, 1);
    send_add(32'h1234_5678, 0, 1'b0, 32'hFFFF_FFFF, 9);   // default route
    send_lookup(32'h7FFF_FFFF, 2);
    send_lookup(32'hC0A8_0105, 255);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned n, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_random(ADD_PCT);
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Output held off long enough that the block backs up into its input.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    repeat (12) send_random(30);
    wait_drained();
  endtask

  // Receiver ready: random stalls, or a counted hold-off on request.
  initial begin : rx_ready_gen
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker: each output transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, status %0d", m_axis_tuser_o));
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tuser_o !== want.status)
          flag_mismatch($sformatf("status %0d, expected %s", m_axis_tuser_o,
                                  want.status.name()));
        if (got.port !== want.port)
          flag_mismatch($sformatf("interface %0d, expected %0d", got.port, want.port));
        if (got.hop !== want.hop)
          flag_mismatch($sformatf("hop %h, expected %h", got.hop, want.hop));
        if (got.ttl !== want.ttl)
          flag_mismatch($sformatf("ttl %0d, expected %0d", got.ttl, want.ttl));
      end
    end
  end

  initial begin : watchdog
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending_verdicts.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = ACT_ADD;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    tbl_count       = 0;
    mismatch_cnt    = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b0;
    hold_left       = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_directed_routes();
    test_random_traffic(260, 0, 0);
    test_output_backpressure();
    test_random_traffic(250, 86, 0);
    test_random_traffic(250, 0, 86);
    test_random_traffic(250, 28, 28);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_verdicts.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));

    $display("Run: %0d route adds (%0d refused on a full table), %0d routes stored",
             status_seen[ST_ADDED] + status_seen[ST_TABLE_FULL],
             status_seen[ST_TABLE_FULL], tbl_count);
    $display("Lookups: %0d forwarded, %0d no route, %0d TTL expired; %0d mismatches",
             status_seen[ST_FORWARDED], status_seen[ST_NO_ROUTE],
             status_seen[ST_TTL_EXPIRED], mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
